FILE: src/frequency_table_header_parser_assert.svh
// Assertion macros used by the parser block.
`ifndef FREQUENCY_TABLE_HEADER_PARSER_ASSERT_SVH
`define FREQUENCY_TABLE_HEADER_PARSER_ASSERT_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define FTHP_ASSERT_NOW(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("fthp assertion failed");

// Next-cycle implication, sampled on clock, off during reset.
`define FTHP_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("fthp assertion failed");

`endif

FILE: src/fthp_pkg.sv
package fthp_pkg;

   localparam int NUM_SYMBOLS_DEF = 256;
   localparam int BYTE_W          = 8;
   localparam int FREQ_W          = 32;
   localparam int ENTRY_W         = 16;
   localparam int IDX_W           = 8;
   localparam int SYM_W           = 9;
   localparam int FMT_W           = 2;
   localparam int COUNT_BYTES     = 4;

   localparam logic [FMT_W-1:0] FMT_NAIVE   = 2'd0;
   localparam logic [FMT_W-1:0] FMT_SPARSE  = 2'd1;
   localparam logic [FMT_W-1:0] FMT_BITMASK = 2'd2;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_NAIVE,
      PH_SP_HEAD,
      PH_SP_SYM,
      PH_SP_LEN,
      PH_SP_DATA,
      PH_BM_MASK,
      PH_BM_COUNT
   } phase_type;

   typedef struct packed {
      logic [BYTE_W-1:0] meta_byte;
      logic              table_start;
   } item_type;

   typedef struct packed {
      logic [BYTE_W-1:0] symbol;
      logic [FREQ_W-1:0] frequency;
      logic              entry_present;
      logic              last_entry;
   } result_type;

endpackage

FILE: src/fthp_next_present.sv
module fthp_next_present #(
   parameter int NumSymbols = fthp_pkg::NUM_SYMBOLS_DEF
) (
   input  logic [NumSymbols-1:0]        present,
   input  logic [fthp_pkg::SYM_W-1:0]   from_sym,
   output logic                         found,
   output logic [fthp_pkg::SYM_W-1:0]   found_sym
);

   always_comb begin
      found     = 1'b0;
      found_sym = '0;
      for (int s = NumSymbols - 1; s >= 0; s--) begin
         if (present[s] && (fthp_pkg::SYM_W'(s) >= from_sym)) begin
            found     = 1'b1;
            found_sym = fthp_pkg::SYM_W'(s);
         end
      end
   end

endmodule

FILE: src/fthp_parser.sv
`include "frequency_table_header_parser_assert.svh"

module fthp_parser #(
   parameter int NumSymbols = fthp_pkg::NUM_SYMBOLS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   input  fthp_pkg::item_type             in_item,
   input  logic [fthp_pkg::FMT_W-1:0]     table_format,
   output logic                           consume,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output fthp_pkg::result_type           rsp
);

   localparam int MaskBytes = (NumSymbols + 7) / 8;

   fthp_pkg::phase_type                   phase_ff, phase_in, phase_cur;
   logic [fthp_pkg::ENTRY_W-1:0]          left_ff, left_in, left_cur;
   logic [fthp_pkg::IDX_W-1:0]            idx_ff, idx_in, idx_cur;
   logic [fthp_pkg::IDX_W-1:0]            total_ff, total_in, total_cur;
   logic [fthp_pkg::FREQ_W-1:0]           acc_ff, acc_in, acc_cur;
   logic [fthp_pkg::SYM_W-1:0]            sym_ff, sym_in, sym_cur;
   logic [fthp_pkg::BYTE_W-1:0]           mask_ff [MaskBytes];
   logic [fthp_pkg::BYTE_W-1:0]           mask_in [MaskBytes];
   logic                                  rsp_valid_ff;
   fthp_pkg::result_type                  rsp_ff, rsp_in;

   logic                                  advance;
   logic                                  emit;
   logic [fthp_pkg::BYTE_W-1:0]           b;
   logic [fthp_pkg::FREQ_W-1:0]           acc_shift;
   logic [fthp_pkg::IDX_W-1:0]            idx_inc;
   logic [fthp_pkg::SYM_W-1:0]            sym_inc;
   logic [fthp_pkg::ENTRY_W-1:0]          left_dec;
   logic [fthp_pkg::ENTRY_W-1:0]          head_left;
   logic                                  naive_last;
   logic                                  count_done;
   logic [NumSymbols-1:0]                 present;
   logic [fthp_pkg::SYM_W-1:0]            from_sym;
   logic                                  found;
   logic [fthp_pkg::SYM_W-1:0]            found_sym;

   assign advance   = in_valid && (!rsp_valid_ff || !rsp_stall);
   assign consume   = advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;
   assign b         = in_item.meta_byte;

   // restart applies before the byte is parsed
   always_comb begin
      phase_cur = phase_ff;
      left_cur  = left_ff;
      idx_cur   = idx_ff;
      total_cur = total_ff;
      acc_cur   = acc_ff;
      sym_cur   = sym_ff;
      if (in_item.table_start) begin
         left_cur  = '0;
         idx_cur   = '0;
         total_cur = '0;
         acc_cur   = '0;
         sym_cur   = '0;
         case (table_format)
            fthp_pkg::FMT_NAIVE:   phase_cur = fthp_pkg::PH_NAIVE;
            fthp_pkg::FMT_SPARSE:  phase_cur = fthp_pkg::PH_SP_HEAD;
            fthp_pkg::FMT_BITMASK: phase_cur = fthp_pkg::PH_BM_MASK;
            default:               phase_cur = fthp_pkg::PH_IDLE;
         endcase
      end
   end

   assign acc_shift  = {acc_cur[fthp_pkg::FREQ_W-fthp_pkg::BYTE_W-1:0], b};
   assign idx_inc    = idx_cur + fthp_pkg::IDX_W'(1);
   assign sym_inc    = sym_cur + fthp_pkg::SYM_W'(1);
   assign left_dec   = left_cur - fthp_pkg::ENTRY_W'(1);
   assign head_left  = {left_cur[fthp_pkg::BYTE_W-1:0], b};
   assign naive_last = sym_inc >= fthp_pkg::SYM_W'(NumSymbols);
   assign count_done = idx_inc >= fthp_pkg::IDX_W'(fthp_pkg::COUNT_BYTES);

   always_comb begin
      for (int i = 0; i < MaskBytes; i++) begin
         if (phase_cur == fthp_pkg::PH_BM_MASK && idx_cur == fthp_pkg::IDX_W'(i)) begin
            mask_in[i] = b;
         end else begin
            mask_in[i] = mask_ff[i];
         end
      end
      for (int s = 0; s < NumSymbols; s++) begin
         present[s] = mask_in[s >> 3][3'(7 - (s & 7))];
      end
   end

   assign from_sym = (phase_cur == fthp_pkg::PH_BM_COUNT) ? sym_inc : '0;

   fthp_next_present #(
      .NumSymbols (NumSymbols)
   ) u_next_present (
      .present   (present),
      .from_sym  (from_sym),
      .found     (found),
      .found_sym (found_sym)
   );

   always_comb begin
      phase_in = phase_cur;
      left_in  = left_cur;
      idx_in   = idx_cur;
      total_in = total_cur;
      acc_in   = acc_cur;
      sym_in   = sym_cur;
      case (phase_cur)
         fthp_pkg::PH_NAIVE: begin
            acc_in = acc_shift;
            idx_in = idx_inc;
            if (count_done) begin
               idx_in = '0;
               acc_in = '0;
               sym_in = sym_inc;
               if (naive_last) begin
                  phase_in = fthp_pkg::PH_IDLE;
               end
            end
         end
         fthp_pkg::PH_SP_HEAD: begin
            if (idx_cur == '0) begin
               left_in = fthp_pkg::ENTRY_W'(b);
               idx_in  = fthp_pkg::IDX_W'(1);
            end else begin
               left_in  = head_left;
               idx_in   = '0;
               phase_in = (head_left == '0) ? fthp_pkg::PH_IDLE : fthp_pkg::PH_SP_SYM;
            end
         end
         fthp_pkg::PH_SP_SYM: begin
            sym_in   = fthp_pkg::SYM_W'(b);
            phase_in = fthp_pkg::PH_SP_LEN;
         end
         fthp_pkg::PH_SP_LEN: begin
            total_in = b;
            idx_in   = '0;
            acc_in   = '0;
            if (b == '0) begin
               left_in  = left_dec;
               phase_in = (left_dec == '0) ? fthp_pkg::PH_IDLE : fthp_pkg::PH_SP_SYM;
            end else begin
               phase_in = fthp_pkg::PH_SP_DATA;
            end
         end
         fthp_pkg::PH_SP_DATA: begin
            acc_in = acc_shift;
            idx_in = idx_inc;
            if (idx_inc >= total_cur) begin
               left_in  = left_dec;
               phase_in = (left_dec == '0) ? fthp_pkg::PH_IDLE : fthp_pkg::PH_SP_SYM;
            end
         end
         fthp_pkg::PH_BM_MASK: begin
            idx_in = idx_inc;
            if (idx_inc >= fthp_pkg::IDX_W'(MaskBytes)) begin
               idx_in = '0;
               acc_in = '0;
               if (found) begin
                  sym_in   = found_sym;
                  phase_in = fthp_pkg::PH_BM_COUNT;
               end else begin
                  phase_in = fthp_pkg::PH_IDLE;
               end
            end
         end
         fthp_pkg::PH_BM_COUNT: begin
            acc_in = acc_shift;
            idx_in = idx_inc;
            if (count_done) begin
               idx_in = '0;
               acc_in = '0;
               if (found) begin
                  sym_in = found_sym;
               end else begin
                  phase_in = fthp_pkg::PH_IDLE;
               end
            end
         end
         default: begin
            phase_in = fthp_pkg::PH_IDLE;
         end
      endcase
   end

   always_comb begin
      emit   = 1'b0;
      rsp_in = '0;
      case (phase_cur)
         fthp_pkg::PH_NAIVE: begin
            emit   = count_done;
            rsp_in = '{sym_cur[fthp_pkg::BYTE_W-1:0], acc_shift, 1'b1, naive_last};
         end
         fthp_pkg::PH_SP_HEAD: begin
            emit   = (idx_cur != '0) && (head_left == '0);
            rsp_in = '{'0, '0, 1'b0, 1'b1};
         end
         fthp_pkg::PH_SP_LEN: begin
            emit   = (b == '0);
            rsp_in = '{sym_cur[fthp_pkg::BYTE_W-1:0], '0, 1'b1, left_dec == '0};
         end
         fthp_pkg::PH_SP_DATA: begin
            emit   = idx_inc >= total_cur;
            rsp_in = '{sym_cur[fthp_pkg::BYTE_W-1:0], acc_shift, 1'b1, left_dec == '0};
         end
         fthp_pkg::PH_BM_MASK: begin
            emit   = (idx_inc >= fthp_pkg::IDX_W'(MaskBytes)) && !found;
            rsp_in = '{'0, '0, 1'b0, 1'b1};
         end
         fthp_pkg::PH_BM_COUNT: begin
            emit   = count_done;
            rsp_in = '{sym_cur[fthp_pkg::BYTE_W-1:0], acc_shift, 1'b1, !found};
         end
         default: begin
            emit   = 1'b0;
            rsp_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= fthp_pkg::PH_IDLE;
         left_ff  <= '0;
         idx_ff   <= '0;
         total_ff <= '0;
         acc_ff   <= '0;
         sym_ff   <= '0;
      end else if (advance) begin
         phase_ff <= phase_in;
         left_ff  <= left_in;
         idx_ff   <= idx_in;
         total_ff <= total_in;
         acc_ff   <= acc_in;
         sym_ff   <= sym_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mask_ff <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= emit;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         rsp_ff <= rsp_in;
      end
   end

   `FTHP_ASSERT_NOW(a_terminator_form, rsp_valid_ff && !rsp_ff.entry_present,
      rsp_ff.last_entry && rsp_ff.frequency == '0 && rsp_ff.symbol == '0)
   `FTHP_ASSERT_NEXT(a_last_goes_idle, advance && emit && rsp_in.last_entry,
      phase_ff == fthp_pkg::PH_IDLE)
   `FTHP_ASSERT_NOW(a_count_index_range, phase_ff == fthp_pkg::PH_BM_COUNT,
      idx_ff < fthp_pkg::IDX_W'(fthp_pkg::COUNT_BYTES))
   `FTHP_ASSERT_NOW(a_data_has_length, phase_ff == fthp_pkg::PH_SP_DATA,
      total_ff != '0 && idx_ff < total_ff)

endmodule

FILE: src/frequency_table_header_parser.sv
// A header byte accepted into the input register is parsed from there, and any result beat
// that it completes is registered in the result register that drives the rsp ports.
// Throughput: one header byte per cycle; the input register advances whenever the
// result register is empty or being drained.
// Reset (synchronous, active high): parser goes to waiting for table start, counters
// clear, both beat registers empty, table_format returns to sparse.
module frequency_table_header_parser #(
   parameter int NumSymbols = fthp_pkg::NUM_SYMBOLS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [fthp_pkg::FMT_W-1:0]     csr_wr_data,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [fthp_pkg::BYTE_W-1:0]    req_meta_byte,
   input  logic                           req_table_start,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [fthp_pkg::BYTE_W-1:0]    rsp_symbol,
   output logic [fthp_pkg::FREQ_W-1:0]    rsp_frequency,
   output logic                           rsp_entry_present,
   output logic                           rsp_last_entry
);

   logic [fthp_pkg::FMT_W-1:0] format_ff;
   logic                       in_valid_ff;
   fthp_pkg::item_type         in_item_ff;
   logic                       consume;
   fthp_pkg::result_type       rsp;

   assign req_stall = in_valid_ff && !consume;

   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff <= fthp_pkg::FMT_SPARSE;
      end else if (csr_wr_en) begin
         format_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_item_ff <= '{req_meta_byte, req_table_start};
      end
   end

   fthp_parser #(
      .NumSymbols (NumSymbols)
   ) u_parser (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (in_valid_ff),
      .in_item      (in_item_ff),
      .table_format (format_ff),
      .consume      (consume),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp          (rsp)
   );

   assign rsp_symbol        = rsp.symbol;
   assign rsp_frequency     = rsp.frequency;
   assign rsp_entry_present = rsp.entry_present;
   assign rsp_last_entry    = rsp.last_entry;

endmodule
